/* src/hsd_pkg.sv */
// Shared constants and types for the stream decoder.
package hsd_pkg;

  localparam int MaxNodes   = 511;
  localparam int StackDepth = 256;
  localparam int IdxW       = 9;
  localparam int SpW        = 9;
  localparam int NodeW      = 27;
  localparam int StkW       = 10;

  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrOverrun = 2'd1;
  localparam logic [1:0] ErrSingle  = 2'd2;

  localparam logic [IdxW-1:0] RootIdx = '0;

  // Node entry: leaf flag, symbol, right child, left child.
  typedef struct packed {
    logic            leaf;
    logic [7:0]      sym;
    logic [IdxW-1:0] right;
    logic [IdxW-1:0] left;
  } node_t;

  // Node table access from the control unit.
  typedef struct packed {
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    node_t           wr_data;
  } node_req_t;

endpackage

/* src/hsd_node_ram.sv */
// Node table: one write port and one registered read port.
module hsd_node_ram (
  input  logic              clk,
  input  hsd_pkg::node_req_t req,
  output hsd_pkg::node_t     rd_data
);
  import hsd_pkg::*;

  node_t mem [MaxNodes];

  // Synchronous write and read.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

/* src/huffman_stream_decoder_core.sv */
// Top level: byte parser, tree builder and bit walker of the stream decoder.
// Size, leaf-flag and ignored bytes stay in idle; a node byte also passes push, after attach
// when it joins a waiting parent (stack read, parent read, write back). A data byte passes
// branch read, child read and check for each code bit, and a flush when two symbols end it.
// The input waits while a result is held; symbols pass a pending and an output register.
// Synchronous active-low reset returns to the size phase; table contents are kept.
module huffman_stream_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_in_byte,
  input  logic       in_start_of_file,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_symbol,
  output logic       out_last,
  output logic       out_done_res,
  output logic [1:0] out_error
);
  import hsd_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ATT  = 7'b0000010,
    S_PUSH = 7'b0000100,
    S_BRD  = 7'b0001000,
    S_CRD  = 7'b0010000,
    S_CHK  = 7'b0100000,
    S_FLSH = 7'b1000000
  } st_t;

  typedef enum logic [5:0] {
    PH_SIZE = 6'b000001,
    PH_FLAG = 6'b000010,
    PH_SYM  = 6'b000100,
    PH_DATA = 6'b001000,
    PH_DONE = 6'b010000,
    PH_ERR  = 6'b100000
  } ph_t;

  st_t st_r, st_nxt;
  ph_t ph_r, ph_nxt;
  logic [1:0]      sbi_r, sbi_nxt;
  logic [31:0]     rem_r, rem_nxt;
  logic [9:0]      cnt_r, cnt_nxt;
  logic [SpW-1:0]  sp_r, sp_nxt;
  logic [IdxW-1:0] walk_r, walk_nxt;
  logic [7:0]      byte_r, byte_nxt;
  logic [2:0]      bit_r, bit_nxt;
  logic            isint_r, isint_nxt;
  logic [IdxW-1:0] newn_r, newn_nxt;
  logic [StkW-1:0] top_r, top_nxt;

  logic            ov_r, ov_nxt;
  logic [7:0]      osym_r, osym_nxt;
  logic            olast_r, olast_nxt, odone_r, odone_nxt;
  logic [1:0]      oerr_r, oerr_nxt;

  // Symbol held back until it is known whether it ends its byte.
  logic            pend_r, pend_nxt;
  logic [7:0]      psym_r, psym_nxt;
  logic            pdone_r, pdone_nxt;

  // Pending-parent stack: a synchronous memory with a registered read.
  logic [StkW-1:0] stk [StackDepth];
  logic            stk_we;
  logic [7:0]      stk_wa;
  logic [StkW-1:0] stk_wd;
  logic            stk_re;
  logic [7:0]      stk_ra;
  logic [StkW-1:0] stk_rd;

  node_req_t nreq;
  node_t     nrd;

  hsd_node_ram u_ram (.clk(clk), .req(nreq), .rd_data(nrd));

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk[stk_wa] <= stk_wd;
    end
    if (stk_re) begin
      stk_rd <= stk[stk_ra];
    end
  end

  logic out_free;
  assign out_free = !ov_r || out_ready;
  assign in_ready = (st_r == S_IDLE) && out_free;

  assign out_valid    = ov_r;
  assign out_symbol   = osym_r;
  assign out_last     = olast_r;
  assign out_done_res = odone_r;
  assign out_error    = oerr_r;

  // Control: parse bytes, build the tree, walk code bits.
  always_comb begin
    logic       acc;
    logic       bitv;
    logic [IdxW-1:0] ch;
    ph_t        ph_i;
    logic [1:0] sbi_i;
    logic [31:0] rem_i;
    logic [9:0] cnt_i;
    logic [SpW-1:0] sp_i;
    logic [IdxW-1:0] walk_i;
    logic       add;
    logic       err1;
    logic       leaf;
    logic       fin;
    logic       endb;
    logic       need;
    st_nxt = st_r; ph_nxt = ph_r; sbi_nxt = sbi_r; rem_nxt = rem_r;
    cnt_nxt = cnt_r; sp_nxt = sp_r; walk_nxt = walk_r; byte_nxt = byte_r;
    bit_nxt = bit_r; isint_nxt = isint_r; newn_nxt = newn_r; top_nxt = top_r;
    ov_nxt = ov_r && !out_ready;
    osym_nxt = osym_r; olast_nxt = olast_r; odone_nxt = odone_r; oerr_nxt = oerr_r;
    pend_nxt = pend_r; psym_nxt = psym_r; pdone_nxt = pdone_r;
    nreq = '0;
    stk_we = 1'b0; stk_wa = '0; stk_wd = '0;
    stk_re = 1'b0; stk_ra = '0;
    acc = in_valid && in_ready;
    bitv = byte_r[bit_r];
    ch = '0;
    ph_i = ph_r; sbi_i = sbi_r; rem_i = rem_r; cnt_i = cnt_r; sp_i = sp_r;
    walk_i = walk_r; add = 1'b0; err1 = 1'b0;
    leaf = 1'b0; fin = 1'b0; endb = 1'b0; need = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (acc) begin
          if (in_start_of_file) begin
            ph_i = PH_SIZE; sbi_i = '0; rem_i = '0; cnt_i = '0; sp_i = '0;
            walk_i = RootIdx;
          end
          ph_nxt = ph_i; sbi_nxt = sbi_i; rem_nxt = rem_i; cnt_nxt = cnt_i;
          sp_nxt = sp_i; walk_nxt = walk_i; byte_nxt = in_in_byte;
          unique case (ph_i)
            PH_SIZE: begin
              rem_nxt = rem_i | (32'(in_in_byte) << {sbi_i, 3'b000});
              if (sbi_i == 2'd3) ph_nxt = PH_FLAG;
              sbi_nxt = sbi_i + 2'd1;
            end
            PH_FLAG: begin
              if (in_in_byte != 8'd0) ph_nxt = PH_SYM;
              else begin add = 1'b1; isint_nxt = 1'b1; end
            end
            PH_SYM: begin add = 1'b1; isint_nxt = 1'b0; end
            PH_DATA: begin
              bit_nxt = 3'd7;
              nreq.rd_en = 1'b1; nreq.rd_addr = walk_i;
              st_nxt = S_BRD;
            end
            default: ;
          endcase
          if (add) begin
            if (cnt_i >= 10'(MaxNodes)) err1 = 1'b1;
            else begin
              newn_nxt = cnt_i[IdxW-1:0];
              cnt_nxt = cnt_i + 10'd1;
              nreq.wr_en = 1'b1; nreq.wr_addr = cnt_i[IdxW-1:0];
              nreq.wr_data = '0;
              nreq.wr_data.leaf = (ph_i == PH_SYM);
              nreq.wr_data.sym = (ph_i == PH_SYM) ? in_in_byte : 8'd0;
              if (sp_i != '0) begin
                stk_re = 1'b1; stk_ra = 8'(sp_i - SpW'(1));
                st_nxt = S_ATT;
              end else begin
                bit_nxt = 3'd0;
                st_nxt = S_PUSH;
              end
            end
          end
          if (err1) begin
            ph_nxt = PH_ERR; ov_nxt = 1'b1; osym_nxt = '0; olast_nxt = 1'b1;
            odone_nxt = 1'b0; oerr_nxt = ErrOverrun;
          end
        end
      end
      S_ATT: begin
        // The stack top is ready: read the waiting parent and mark its left side taken if it was free.
        nreq.rd_en = 1'b1; nreq.rd_addr = stk_rd[IdxW-1:0];
        if (!stk_rd[StkW-1]) begin
          stk_we = 1'b1; stk_wa = 8'(sp_r - SpW'(1)); stk_wd = stk_rd | 10'h200;
        end
        st_nxt = S_PUSH;
        isint_nxt = isint_r;
        top_nxt = stk_rd;
        // A bit_r of one marks the deferred attach.
        bit_nxt = 3'd1;
      end
      S_PUSH: begin
        sp_i = sp_r;
        if (bit_r == 3'd1) begin
          nreq.wr_en = 1'b1; nreq.wr_addr = top_r[IdxW-1:0];
          nreq.wr_data = nrd;
          if (!top_r[StkW-1]) begin
            nreq.wr_data.left = newn_r;
          end else begin
            nreq.wr_data.right = newn_r;
            sp_i = sp_r - SpW'(1);
          end
        end
        bit_nxt = 3'd0;
        sp_nxt = sp_i;
        st_nxt = S_IDLE;
        if (isint_r) begin
          if (sp_i >= SpW'(StackDepth)) err1 = 1'b1;
          else begin
            stk_we = 1'b1; stk_wa = 8'(sp_i); stk_wd = {1'b0, newn_r};
            sp_nxt = sp_i + SpW'(1);
            ph_nxt = PH_FLAG;
          end
        end else if (sp_i == '0) begin
          if (cnt_r == 10'd1) begin
            ph_nxt = PH_ERR; ov_nxt = 1'b1; osym_nxt = '0; olast_nxt = 1'b1;
            odone_nxt = 1'b0; oerr_nxt = ErrSingle;
          end else begin
            walk_nxt = RootIdx;
            ph_nxt = (rem_r == '0) ? PH_DONE : PH_DATA;
          end
        end else ph_nxt = PH_FLAG;
        if (err1) begin
          ph_nxt = PH_ERR; ov_nxt = 1'b1; osym_nxt = '0; olast_nxt = 1'b1;
          odone_nxt = 1'b0; oerr_nxt = ErrOverrun;
        end
      end
      S_BRD: begin
        // Current node data is ready: pick the child and read it.
        ch = bitv ? nrd.right : nrd.left;
        if (ch >= IdxW'(MaxNodes)) ch = RootIdx;
        walk_nxt = ch;
        nreq.rd_en = 1'b1; nreq.rd_addr = ch;
        st_nxt = S_CRD;
      end
      S_CRD: begin
        st_nxt = S_CHK;
      end
      S_CHK: begin
        // The child is ready. A new symbol, unless it ends its byte with none held, waits in the
        // pending register until the next symbol or the end of the byte decides its last flag.
        leaf = nrd.leaf;
        fin  = nrd.leaf && (rem_r == 32'd1);
        endb = fin || (bit_r == 3'd0);
        need = (leaf && pend_r) || (endb && (leaf || pend_r));
        if (need && !out_free) begin
          st_nxt = S_CHK;
        end else begin
          if (leaf) begin
            rem_nxt = rem_r - 32'd1;
            walk_nxt = RootIdx;
          end
          if (fin) ph_nxt = PH_DONE;
          if (leaf && pend_r) begin
            ov_nxt = 1'b1; osym_nxt = psym_r; olast_nxt = 1'b0;
            odone_nxt = pdone_r; oerr_nxt = ErrNone;
            psym_nxt = nrd.sym; pdone_nxt = fin;
          end else if (leaf && endb) begin
            ov_nxt = 1'b1; osym_nxt = nrd.sym; olast_nxt = 1'b1;
            odone_nxt = fin; oerr_nxt = ErrNone;
          end else if (leaf) begin
            pend_nxt = 1'b1; psym_nxt = nrd.sym; pdone_nxt = 1'b0;
          end else if (endb && pend_r) begin
            ov_nxt = 1'b1; osym_nxt = psym_r; olast_nxt = 1'b1;
            odone_nxt = pdone_r; oerr_nxt = ErrNone;
            pend_nxt = 1'b0;
          end
          if (leaf && pend_r && endb) begin
            st_nxt = S_FLSH;
          end else if (endb) begin
            st_nxt = S_IDLE;
          end else begin
            bit_nxt = bit_r - 3'd1;
            nreq.rd_en = 1'b1;
            nreq.rd_addr = leaf ? RootIdx : walk_r;
            st_nxt = S_BRD;
          end
        end
      end
      S_FLSH: begin
        // Send the held symbol as the last result of its byte.
        if (out_free) begin
          ov_nxt = 1'b1; osym_nxt = psym_r; olast_nxt = 1'b1;
          odone_nxt = pdone_r; oerr_nxt = ErrNone;
          pend_nxt = 1'b0;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ph_r <= PH_SIZE; sbi_r <= '0; rem_r <= '0; cnt_r <= '0;
      sp_r <= '0; walk_r <= RootIdx; ov_r <= 1'b0; bit_r <= '0; pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; sbi_r <= sbi_nxt; rem_r <= rem_nxt;
      cnt_r <= cnt_nxt; sp_r <= sp_nxt; walk_r <= walk_nxt; ov_r <= ov_nxt;
      bit_r <= bit_nxt; pend_r <= pend_nxt;
    end
    byte_r <= byte_nxt; isint_r <= isint_nxt; newn_r <= newn_nxt; top_r <= top_nxt;
    osym_r <= osym_nxt; olast_r <= olast_nxt; odone_r <= odone_nxt; oerr_r <= oerr_nxt;
    psym_r <= psym_nxt; pdone_r <= pdone_nxt;
  end

  // Input is only taken while the control unit is idle.
  a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (st_r == S_IDLE)) else $error("accept while busy");
  // A held result is never overwritten.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_symbol)) else $error("result lost");
  // The node count never passes the table size.
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 10'(MaxNodes)) else $error("node count overflow");
  // Error results carry no symbol.
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error != ErrNone) |-> (out_symbol == 8'd0))
    else $error("error with symbol");

endmodule

/* sim/huffman_stream_decoder_core_test.sv */
// Testbench for the stream decoder: directed and random compressed files checked against a predictor.
module huffman_stream_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hsd_pkg::*;

  typedef enum logic [2:0] {
    PhSize, PhFlag, PhSym, PhData, PhDone, PhErr
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
    logic       done_res;
    logic [1:0] error;
  } decode_res_t;

  // Predictor of the decoder plus the queue of results still owed.
  class decode_scoreboard_t;
    parse_phase_t    phase;
    logic [1:0]      size_idx;
    logic [31:0]     remaining;
    node_t           nodes[MaxNodes];
    logic [StkW-1:0] parents[StackDepth];
    int              node_cnt;
    int              sp;
    int              walk;
    decode_res_t     owed[$];
    int              errors;

    function new();
      phase = PhSize; size_idx = 0; remaining = 0;
      node_cnt = 0; sp = 0; walk = 0; errors = 0;
    endfunction

    // Append a node and hook it onto the waiting parent; returns 1 on overrun.
    function bit add_node(node_t entry, bit internal);
      int n, p;
      logic [StkW-1:0] top;
      if (node_cnt >= MaxNodes) return 1;
      n = node_cnt;
      nodes[n] = entry;
      node_cnt++;
      if (sp > 0) begin
        top = parents[sp-1];
        p = top[IdxW-1:0];
        if (p < MaxNodes) begin
          if (!top[IdxW]) begin
            nodes[p].left = IdxW'(n);
            parents[sp-1] = top | StkW'(1 << IdxW);
          end else begin
            nodes[p].right = IdxW'(n);
            sp--;
          end
        end
      end
      if (internal) begin
        if (sp >= StackDepth) return 1;
        parents[sp] = StkW'(n);
        sp++;
      end
      return 0;
    endfunction

    // Note an accepted request and queue the results it causes.
    function void note_request(logic [7:0] b, logic sof);
      decode_res_t r[$];
      decode_res_t e;
      logic [1:0] err;
      int child;
      node_t cur;
      err = ErrNone;
      if (sof) begin
        phase = PhSize; size_idx = 0; remaining = 0;
        node_cnt = 0; sp = 0; walk = 0;
      end
      case (phase)
        PhSize: begin
          remaining |= 32'(b) << (8 * size_idx);
          if (size_idx == 3) phase = PhFlag;
          size_idx++;
        end
        PhFlag: begin
          if (b != 0) phase = PhSym;
          else if (add_node('0, 1)) err = ErrOverrun;
        end
        PhSym: begin
          e = '0;
          if (add_node({1'b1, b, 18'd0}, 0)) err = ErrOverrun;
          else if (sp == 0) begin
            if (node_cnt == 1) err = ErrSingle;
            else begin
              walk = 0;
              phase = (remaining == 0) ? PhDone : PhData;
            end
          end else phase = PhFlag;
        end
        PhData: begin
          for (int i = 7; i >= 0; i--) begin
            cur = (walk < MaxNodes) ? nodes[walk] : '0;
            child = b[i] ? cur.right : cur.left;
            if (child >= MaxNodes) child = 0;
            walk = child;
            if (nodes[child].leaf) begin
              remaining--;
              walk = 0;
              e = '0;
              e.symbol = nodes[child].sym;
              e.done_res = (remaining == 0);
              r.push_back(e);
              if (remaining == 0) begin
                phase = PhDone;
                break;
              end
            end
          end
        end
        default: ;
      endcase
      if (err != ErrNone) begin
        phase = PhErr;
        r.delete();
        e = '0;
        e.error = err;
        r.push_back(e);
      end
      if (r.size() > 0) r[r.size()-1].last = 1;
      foreach (r[i]) owed.push_back(r[i]);
    endfunction

    // Compare one accepted result with the oldest owed one.
    function void check_result(decode_res_t got);
      decode_res_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (want.symbol !== got.symbol)
        $display("%0t: symbol expected %h actual %h", $time, want.symbol, got.symbol);
      if (want.last !== got.last)
        $display("%0t: last expected %b actual %b", $time, want.last, got.last);
      if (want.done_res !== got.done_res)
        $display("%0t: done_res expected %b actual %b", $time, want.done_res,
                 got.done_res);
      if (want.error !== got.error)
        $display("%0t: error expected %0d actual %0d", $time, want.error, got.error);
      if (want !== got) errors++;
    endfunction
  endclass

  logic       clk = 0;
  logic       rst_n = 0;
  logic       in_valid = 0;
  logic       in_ready;
  logic [7:0] in_in_byte = 0;
  logic       in_start_of_file = 0;
  logic       out_valid;
  logic       out_ready = 0;
  logic [7:0] out_symbol;
  logic       out_last;
  logic       out_done_res;
  logic [1:0] out_error;

  decode_scoreboard_t board = new();
  bit   calm = 0;         // no idling on either side while set
  bit   stall_go = 0;     // asks the receiver for its long hold-off
  bit   stall_taken = 0;  // the receiver has started that hold-off
  int   hold_off = 0;     // receiver stall still to run, in cycles
  logic [7:0] file_q[$];
  logic       sof_q[$];

  huffman_stream_decoder_core uut (.*);

  always #2 clk = ~clk;

  // Send one request, with random idle cycles ahead of it.
  task automatic send_byte(logic [7:0] b, logic sof);
    if (!calm && $urandom_range(99) < 13) begin
      in_valid <= 0;
      @(posedge clk);
      while (!calm && $urandom_range(99) < 13) @(posedge clk);
    end
    in_valid <= 1;
    in_in_byte <= b;
    in_start_of_file <= sof;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(b, sof);
  endtask

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result({out_symbol, out_last, out_done_res, out_error});
    if (stall_go && !stall_taken) begin
      stall_taken <= 1;
      hold_off <= 300;
      out_ready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 0;
    end else
      out_ready <= calm || ($urandom_range(99) >= 13);
  end

  // Build a random well-formed tree with nleaves leaves into the file queue.
  function automatic void put_tree(int nleaves);
    int split;
    if (nleaves <= 1) begin
      file_q.push_back(8'($urandom_range(1, 255)));
      file_q.push_back(8'($urandom_range(255)));
      return;
    end
    file_q.push_back(8'd0);
    split = $urandom_range(1, nleaves - 1);
    put_tree(split);
    put_tree(nleaves - split);
  endfunction

  // Queue a whole file: count, tree with nleaves leaves and data bytes.
  function automatic void put_file(logic [31:0] count, int nleaves, int ndata);
    int first;
    first = file_q.size();
    for (int i = 0; i < 4; i++) file_q.push_back(count[8*i +: 8]);
    put_tree(nleaves);
    for (int i = 0; i < ndata; i++) file_q.push_back(8'($urandom));
    for (int i = first; i < file_q.size(); i++) sof_q.push_back(i == first);
  endfunction

  task automatic flush_files();
    while (file_q.size() > 0) send_byte(file_q.pop_front(), sof_q.pop_front());
    file_q.delete();
    sof_q.delete();
  endtask

  initial begin
    int sent;
    repeat (7) @(posedge clk);
    rst_n <= 1;

    // Directed: two-leaf tree, extreme bytes, count of one and of many.
    put_file(32'd3, 2, 2);
    flush_files();
    send_byte(8'h01, 1); send_byte(8'h00, 0); send_byte(8'h00, 0); send_byte(8'h00, 0);
    send_byte(8'h00, 0); send_byte(8'hff, 0); send_byte(8'h00, 0); send_byte(8'h80, 0);
    send_byte(8'hff, 0); send_byte(8'h55, 0); send_byte(8'hff, 0); send_byte(8'hff, 0);
    // Single-leaf tree with a zero count, then bytes ignored after it.
    send_byte(8'h00, 1); send_byte(8'h00, 0); send_byte(8'h00, 0); send_byte(8'h00, 0);
    send_byte(8'hff, 0); send_byte(8'h41, 0); send_byte(8'h12, 0);
    // Zero count with a real tree.
    put_file(32'd0, 3, 1);
    // Huge count so that every data bit keeps decoding.
    put_file(32'hffff_ffff, 4, 3);
    flush_files();

    // Long receiver stall while a data-heavy file streams in.
    stall_go = 1;
    put_file(32'd200, 2, 20);
    flush_files();

    // Random files; most are well formed, some are truncated or noise.
    sent = 0;
    while (sent < 40) begin
      case ($urandom_range(9))
        0: begin
          for (int i = 0; i < 6; i++) send_byte(8'($urandom), ($urandom_range(9) == 0));
          sent += 6;
        end
        1: put_file($urandom_range(1, 20), 1, 2);
        default: put_file($urandom_range(1, 40), $urandom_range(2, 12), $urandom_range(1, 8));
      endcase
      sent += file_q.size();
      flush_files();
    end

    // Overrun: a 257-deep left spine overflows the pending stack, sent without idling.
    calm = 1;
    send_byte(8'h05, 1);
    for (int i = 0; i < 3; i++) send_byte(8'h00, 0);
    for (int i = 0; i < 257; i++) send_byte(8'h00, 0);
    calm = 0;
    // Finish with a clean file.
    put_file(32'd5, 3, 4);
    flush_files();
    in_valid <= 0;

    while (board.owed.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0)
      $display("huffman_stream_decoder_core_test: done, clean");
    else
      $display("huffman_stream_decoder_core_test: done, errors");
    $finish;
  end

  initial begin
    #2ms;
    $display("huffman_stream_decoder_core_test: done, errors");
    $finish;
  end
endmodule
